>>> hdl/csbr_pkg.sv
// Shared types and constants for the clipped sprite row blitter.
// Used by csbr_ctrl, csbr_dp and clipped_sprite_blit_rows_unit.
package csbr_pkg;

  localparam int CSBR_MAX_SPRITE = 64;

  localparam int IN_TDATA_W  = 80;   // 78 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_FB_BASE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_HEIGHT = 2'd2;

  localparam logic [31:0] FB_BASE_RST   = 32'd0;
  localparam logic [10:0] FB_WIDTH_RST  = 11'd400;
  localparam logic [10:0] FB_HEIGHT_RST = 11'd240;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_MUL,
    ST_BASE,
    ST_ROWS
  } csbr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input item
    logic clip;   // register clip window
    logic mul;    // register start pixel offsets
    logic base;   // register start byte addresses and steps
    logic emit;   // move one row command into the output register
  } csbr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // item yields no row
    logic last;      // the row about to be emitted is the final one
    logic out_free;  // output register can take a row this cycle
  } csbr_sts_t;

endpackage

>>> hdl/csbr_ctrl.sv
// Sequencer for the sprite row blitter: setup steps, then one row per cycle while the output is free.
// Depends on csbr_pkg.
module csbr_ctrl
  import csbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  csbr_sts_t   sts,
  output csbr_cmd_t   cmd,
  output csbr_state_t state
);

  csbr_state_t state_r, state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        state_nxt = sts.empty ? ST_IDLE : ST_MUL;
      end
      ST_MUL:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_ROWS;
      ST_ROWS: begin
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CLIP: cmd.clip = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_BASE: cmd.base = 1'b1;
      ST_ROWS: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/csbr_dp.sv
// Datapath of the sprite row blitter: config registers, clipping,
// start address setup, row address stepping and the output register.
// Depends on csbr_pkg.
module csbr_dp
  import csbr_pkg::*;
#(
  parameter int MAX_SPRITE_SIZE = CSBR_MAX_SPRITE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  csbr_cmd_t              cmd,
  output csbr_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam logic [6:0] MAX_SZ = 7'(MAX_SPRITE_SIZE);

  // config
  logic [31:0] fb_base_r;
  logic [10:0] fb_width_r, fb_height_r;

  // captured item
  logic [31:0]        sbase_r;
  logic signed [15:0] px_r, py_r;
  logic [6:0]         sw_r, sh_r;

  // clip results
  logic [10:0] col_r, row_r;
  logic [6:0]  xoff_r, yoff_r, wvis_r, rows_left_r;

  logic [22:0] dpix_r;
  logic [13:0] spix_r;

  logic [31:0] dest_r, src_r;
  logic [12:0] dstep_r;
  logic [7:0]  sstep_r, bcnt_r;

  logic        oval_r, olast_r;
  logic [31:0] odest_r, osrc_r;
  logic [7:0]  obcnt_r;

  logic [6:0] sw_in, sh_in;

  logic signed [17:0] px_x, py_x, xend, yend, fw_x, fh_x;
  logic signed [17:0] col0, row0, colend, rowend, wv, hv;
  logic               off_scr;

  assign sw_in = (in_tdata[70:64] > MAX_SZ) ? MAX_SZ : in_tdata[70:64];
  assign sh_in = (in_tdata[77:71] > MAX_SZ) ? MAX_SZ : in_tdata[77:71];

  always_comb begin
    px_x   = {{2{px_r[15]}}, px_r};
    py_x   = {{2{py_r[15]}}, py_r};
    fw_x   = {7'd0, fb_width_r};
    fh_x   = {7'd0, fb_height_r};
    xend   = px_x + {11'd0, sw_r};
    yend   = py_x + {11'd0, sh_r};
    off_scr = (xend < 0) || (px_x >= fw_x) || (yend < 0) || (py_x >= fh_x);
    col0   = (px_x < 0) ? 18'sd0 : px_x;
    row0   = (py_x < 0) ? 18'sd0 : py_x;
    colend = (xend >= fw_x) ? fw_x : xend;
    rowend = (yend >= fh_x) ? fh_x : yend;
    wv     = colend - col0;
    hv     = rowend - row0;
  end

  assign sts.empty    = (sbase_r == 32'd0) || off_scr || (wv <= 0) || (hv <= 0);
  assign sts.last     = (rows_left_r == 7'd1);
  assign sts.out_free = !oval_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_base_r   <= FB_BASE_RST;
      fb_width_r  <= FB_WIDTH_RST;
      fb_height_r <= FB_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FB_BASE:   fb_base_r   <= cfg_wdata;
        REG_FB_WIDTH:  fb_width_r  <= cfg_wdata[10:0];
        REG_FB_HEIGHT: fb_height_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sbase_r <= in_tdata[31:0];
      px_r    <= in_tdata[47:32];
      py_r    <= in_tdata[63:48];
      sw_r    <= sw_in;
      sh_r    <= sh_in;
    end
    // truncations below are exact whenever the item is not empty
    if (cmd.clip) begin
      col_r  <= col0[10:0];
      row_r  <= row0[10:0];
      xoff_r <= (px_x < 0) ? 7'(-px_x) : 7'd0;
      yoff_r <= (py_x < 0) ? 7'(-py_x) : 7'd0;
      wvis_r <= wv[6:0];
    end
    if (cmd.mul) begin
      dpix_r <= 23'(row_r * fb_width_r) + {12'd0, col_r};
      spix_r <= 14'(yoff_r * sw_r) + {7'd0, xoff_r};
    end
    if (cmd.base) begin
      dest_r  <= fb_base_r + {8'd0, dpix_r, 1'b0} + {9'd0, dpix_r};
      src_r   <= sbase_r + {17'd0, spix_r, 1'b0} + {18'd0, spix_r};
      dstep_r <= {1'b0, fb_width_r, 1'b0} + {2'd0, fb_width_r};
      sstep_r <= 8'({sw_r, 1'b0}) + {1'b0, sw_r};
      bcnt_r  <= 8'({wvis_r, 1'b0}) + {1'b0, wvis_r};
    end
    if (cmd.emit) begin
      dest_r  <= dest_r + {19'd0, dstep_r};
      src_r   <= src_r + {24'd0, sstep_r};
      odest_r <= dest_r;
      osrc_r  <= src_r;
      obcnt_r <= bcnt_r;
      olast_r <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_left_r <= '0;
      oval_r      <= 1'b0;
    end else begin
      if (cmd.clip) begin
        rows_left_r <= hv[6:0];
      end else if (cmd.emit) begin
        rows_left_r <= rows_left_r - 7'd1;
      end
      if (cmd.emit) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {obcnt_r, osrc_r, odest_r};
  assign out_tlast  = olast_r;

endmodule

>>> hdl/clipped_sprite_blit_rows_unit.sv
// Clipped sprite row blitter, top level: ties the sequencer to the datapath.
// Depends on csbr_pkg, csbr_ctrl and csbr_dp.
//
// Usage: each in_ item places one RGB888 sprite (base address, signed x/y,
// width, height). The sprite is clipped against the framebuffer set through
// the cfg_ port (fb_base, fb_width, fb_height; write only while idle). For
// every visible row, top to bottom, one out_ item carries the framebuffer
// byte address, the sprite byte address and the byte count (3 per pixel);
// out_tlast marks the final row. A null base, an off-screen sprite or an
// empty clip produces no out_ item.
// Sequence: an item is taken while idle, then clip, multiply and address
// setup run as separate steps (an item with no rows frees the block after
// the clip step). Rows then leave one per cycle through the output register
// while the receiver keeps up. Throughput is set by the single row-stepping
// adder pair. in_tready is high only between items.
// A stalled receiver holds the output register and freezes row stepping.
// Reset (rst_n low, synchronous) clears the sequencer and output valid and
// loads fb_base 0, fb_width 400, fb_height 240.
module clipped_sprite_blit_rows_unit
  import csbr_pkg::*;
#(
  parameter int MAX_SPRITE_SIZE = CSBR_MAX_SPRITE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sprite_base[31:0], pos_x[47:32], pos_y[63:48], sprite_w[70:64],
  // sprite_h[77:71], zero pad[79:78]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // dest_addr[31:0], src_addr[63:32], byte_count[71:64]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  csbr_cmd_t   cmd;
  csbr_sts_t   sts;
  csbr_state_t state;

  csbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  csbr_dp #(
    .MAX_SPRITE_SIZE (MAX_SPRITE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // an accepted item keeps the block busy at least through the clip step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after an item");

  // emitting the final row returns the sequencer to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last |=> in_tready)
    else $error("block not idle after final row");

  // a non-final row leaving means more rows are still pending
  a_rows_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> state == ST_ROWS)
    else $error("non-final row taken with no rows pending");

  // every row command copies at least one pixel
  a_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:64] != 8'd0)
    else $error("row command with zero byte count");

endmodule
